### src/tcw_pkg.sv
package tcw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam logic       CmdPut        = 1'b0;
  localparam logic       CmdRead       = 1'b1;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] ResetAttr     = 8'h07;
  localparam logic [15:0] ResetCell    = {ResetAttr, CharSpace};

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_item_t;

endpackage

### src/text_console_writer_core.sv
// Put: the cell is written at accept, then the result goes to the result register.
// Read: accept, registered RAM read, then the result register.
// A put that scrolls first moves the screen up one row, one cell copy per cycle
// through the single RAM write port, then the last row blanked.
// After reset the screen RAM is swept to blank cells, all Rows*Columns cells
// (2000 by default), during which no transaction is accepted.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int AddrW = $clog2(COLUMNS * ROWS);

  logic [7:0]       attr_q;
  logic             out_valid_q;
  out_item_t        out_data_q;
  logic             res_valid;
  out_item_t        res;
  logic             res_ready;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ResetAttr;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
        if (res_valid) begin
          out_data_q <= res;
        end
      end
    end
  end

  tcw_seq #(
    .Columns(COLUMNS),
    .Rows   (ROWS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .attr_i     (attr_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  tcw_ram #(
    .Width(16),
    .Depth(COLUMNS * ROWS)
  ) u_ram (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/tcw_ram.sv
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/tcw_seq.sv
module tcw_seq import tcw_pkg::*; #(
  parameter int Columns = DefColumns,
  parameter int Rows    = DefRows,
  localparam int AddrW  = $clog2(Columns * Rows)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  input  logic [7:0]       attr_i,
  output logic             res_valid_o,
  output out_item_t        res_o,
  input  logic             res_ready_i,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [15:0]      mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [15:0]      mem_rdata_i
);

  localparam int CellCount = Columns * Rows;
  localparam int CopyN     = (Rows - 1) * Columns;

  typedef enum logic [2:0] {StClear, StIdle, StRead, StScroll, StBlank, StPush} state_e;

  state_e           state_q;
  logic [AddrW-1:0] cnt_q;
  logic [6:0]       col_q;
  logic [4:0]       row_q;
  logic [10:0]      off_q;
  logic             in_range_q;
  logic             wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;
  out_item_t        res_q;

  logic        accept;
  logic        is_put;
  logic [7:0]  ch;
  logic [5:0]  row_ext;
  logic [6:0]  col_n;
  logic [5:0]  row_n;
  logic [4:0]  row_fin;
  logic        need_scroll;
  logic        cell_we;
  logic [15:0] cell_data;
  logic [5:0]  cell_row;
  logic [6:0]  cell_col;
  logic [15:0] cell_idx;
  logic [15:0] fin_idx;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_put     = (in_data_i.command == CmdPut);
  assign ch         = in_data_i.char_code;
  assign row_ext    = {1'b0, row_q};

  always_comb begin
    col_n     = col_q;
    row_n     = row_ext;
    cell_we   = 1'b0;
    cell_data = {attr_i, ch};
    cell_row  = row_ext;
    cell_col  = col_q;
    if (ch == CharNewline) begin
      col_n = '0;
      row_n = row_ext + 6'd1;
    end else if (ch == CharBackspace) begin
      if (col_q != '0) begin
        col_n = col_q - 7'd1;
      end else if (row_q != '0) begin
        row_n = row_ext - 6'd1;
        col_n = 7'(Columns - 1);
      end
      cell_we   = 1'b1;
      cell_data = {attr_i, CharSpace};
      cell_row  = row_n;
      cell_col  = col_n;
    end else begin
      cell_we = 1'b1;
      if (int'(col_q) + 1 >= Columns) begin
        col_n = '0;
        row_n = row_ext + 6'd1;
      end else begin
        col_n = col_q + 7'd1;
      end
    end
  end

  assign need_scroll = (int'(row_n) >= Rows);
  assign row_fin     = need_scroll ? 5'(Rows - 1) : row_n[4:0];
  assign cell_idx    = 16'(cell_row) * 16'(Columns) + 16'(cell_col);
  assign fin_idx     = 16'(row_fin) * 16'(Columns) + 16'(col_n);

  // read port: scroll source row or the requested cell
  assign mem_raddr_o = (state_q == StScroll) ? cnt_q + AddrW'(Columns)
                                             : AddrW'(in_data_i.cell_index);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = {attr_i, CharSpace};
    if (wr_pend_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = wr_addr_q;
      mem_wdata_o = mem_rdata_i;
    end else begin
      unique case (state_q)
        StClear: begin
          mem_we_o    = 1'b1;
          mem_wdata_o = ResetCell;
        end
        StIdle: begin
          mem_we_o    = accept && is_put && cell_we;
          mem_waddr_o = cell_idx[AddrW-1:0];
          mem_wdata_o = cell_data;
        end
        StBlank: begin
          mem_we_o = 1'b1;
        end
        default: begin
          mem_we_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      cnt_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      off_q      <= '0;
      in_range_q <= 1'b0;
      wr_pend_q  <= 1'b0;
      wr_addr_q  <= '0;
      res_q      <= '0;
    end else begin
      wr_pend_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          if (int'(cnt_q) == CellCount - 1) begin
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + AddrW'(1);
          end
        end
        StIdle: begin
          if (accept) begin
            if (is_put) begin
              col_q                <= col_n;
              row_q                <= row_fin;
              off_q                <= fin_idx[10:0];
              res_q.cursor_col     <= col_n;
              res_q.cursor_row     <= row_fin;
              res_q.cursor_offset  <= fin_idx[10:0];
              res_q.cell_value     <= '0;
              res_q.scrolled       <= need_scroll;
              cnt_q                <= '0;
              state_q              <= need_scroll ? StScroll : StPush;
            end else begin
              in_range_q <= (int'(in_data_i.cell_index) < CellCount);
              state_q    <= StRead;
            end
          end
        end
        StRead: begin
          res_q.cursor_col    <= col_q;
          res_q.cursor_row    <= row_q;
          res_q.cursor_offset <= off_q;
          res_q.cell_value    <= in_range_q ? mem_rdata_i : 16'h0000;
          res_q.scrolled      <= 1'b0;
          state_q             <= StPush;
        end
        StScroll: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= cnt_q;
          if (int'(cnt_q) == CopyN - 1) begin
            cnt_q   <= AddrW'(CopyN);
            state_q <= StBlank;
          end else begin
            cnt_q <= cnt_q + AddrW'(1);
          end
        end
        StBlank: begin
          if (!wr_pend_q) begin
            if (int'(cnt_q) == CellCount - 1) begin
              state_q <= StPush;
            end else begin
              cnt_q <= cnt_q + AddrW'(1);
            end
          end
        end
        StPush: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == StPush);
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < Rows && int'(col_q) < Columns)
    else $error("cursor out of screen");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == StScroll || state_q == StBlank))
    else $error("copy write outside scroll");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScroll |-> int'(cnt_q) < CopyN)
    else $error("scroll counter overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush && !res_ready_i) |=> (state_q == StPush && $stable(res_q)))
    else $error("pending result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_put && need_scroll) |=> state_q == StScroll)
    else $error("scroll not started");
`endif

endmodule

### tb/tb_text_console_writer_core.sv
`timescale 1ns / 100ps

module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int ScreenCols  = DefColumns;
  localparam int ScreenRows  = DefRows;
  localparam int CellCount   = ScreenCols * ScreenRows;
  localparam int QuietCycles = CellCount + 100;
  localparam int CycleLimit  = 20_000_000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;

  text_console_writer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // console shadow state
  logic [15:0] screen_shadow [CellCount];
  int          cursor_col_q;
  int          cursor_row_q;
  logic [7:0]  attr_q;

  out_item_t   expected_results [$];
  out_item_t   oldest_result;
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          cycle_count   = 0;

  function automatic logic [15:0] blank_cell();
    return {attr_q, CharSpace};
  endfunction

  function automatic out_item_t predict_console(in_item_t item);
    out_item_t res;
    res = '0;
    if (item.command == CmdRead) begin
      if (int'(item.cell_index) < CellCount) begin
        res.cell_value = screen_shadow[item.cell_index];
      end
    end else begin
      if (item.char_code == CharNewline) begin
        cursor_col_q = 0;
        cursor_row_q++;
      end else if (item.char_code == CharBackspace) begin
        if (cursor_col_q != 0) begin
          cursor_col_q--;
        end else if (cursor_row_q != 0) begin
          cursor_row_q--;
          cursor_col_q = ScreenCols - 1;
        end
        screen_shadow[cursor_row_q * ScreenCols + cursor_col_q] = blank_cell();
      end else begin
        screen_shadow[cursor_row_q * ScreenCols + cursor_col_q] = {attr_q, item.char_code};
        cursor_col_q++;
        if (cursor_col_q >= ScreenCols) begin
          cursor_col_q = 0;
          cursor_row_q++;
        end
      end
      if (cursor_row_q >= ScreenRows) begin
        for (int i = 0; i < (ScreenRows - 1) * ScreenCols; i++) begin
          screen_shadow[i] = screen_shadow[i + ScreenCols];
        end
        for (int i = (ScreenRows - 1) * ScreenCols; i < CellCount; i++) begin
          screen_shadow[i] = blank_cell();
        end
        cursor_row_q = ScreenRows - 1;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_col    = 7'(cursor_col_q);
    res.cursor_row    = 5'(cursor_row_q);
    res.cursor_offset = 11'(cursor_row_q * ScreenCols + cursor_col_q);
    return res;
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [7:0] ch, logic [10:0] idx);
    in_item_t item;
    item.command    = cmd;
    item.char_code  = ch;
    item.cell_index = idx;
    return item;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
             want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_data), 0);
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data.cursor_col !== oldest_result.cursor_col)
          report_mismatch("cursor_col", 32'(out_data.cursor_col),
                          32'(oldest_result.cursor_col));
        if (out_data.cursor_row !== oldest_result.cursor_row)
          report_mismatch("cursor_row", 32'(out_data.cursor_row),
                          32'(oldest_result.cursor_row));
        if (out_data.cursor_offset !== oldest_result.cursor_offset)
          report_mismatch("cursor_offset", 32'(out_data.cursor_offset),
                          32'(oldest_result.cursor_offset));
        if (out_data.cell_value !== oldest_result.cell_value)
          report_mismatch("cell_value", 32'(out_data.cell_value),
                          32'(oldest_result.cell_value));
        if (out_data.scrolled !== oldest_result.scrolled)
          report_mismatch("scrolled", 32'(out_data.scrolled), 32'(oldest_result.scrolled));
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Leaves valid high on return; the caller either sends again in the same
  // step or calls stop_sending.
  task automatic send_item(in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_console(item));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    attr_q = value;
    cfg_we <= 1'b0;
  endtask

  // lines of text with reads mixed in; a quarter of the lines are 70 to 170 items long, so they can wrap
  task automatic send_random_text(int count);
    int          sent;
    int          line_len;
    logic [7:0]  ch;
    logic [10:0] idx;
    sent = 0;
    while (sent < count) begin
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 170) : $urandom_range(0, 40);
      for (int i = 0; i < line_len && sent < count; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          idx = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(CellCount, 2047))
                                             : 11'($urandom_range(0, CellCount - 1));
          send_item(make_item(CmdRead, 8'($urandom_range(0, 255)), idx));
        end else if ($urandom_range(0, 19) == 0) begin
          send_item(make_item(CmdPut, CharBackspace, 11'($urandom_range(0, 2047))));
        end else begin
          do ch = 8'($urandom_range(0, 255)); while (ch == CharNewline || ch == CharBackspace);
          send_item(make_item(CmdPut, ch, 11'($urandom_range(0, 2047))));
        end
        sent++;
      end
      if (sent < count) begin
        send_item(make_item(CmdPut, CharNewline, 11'($urandom_range(0, 2047))));
        sent++;
      end
    end
  endtask

  task automatic test_reset_screen();
    send_item(make_item(CmdRead, 8'h00, 11'd0));
    send_item(make_item(CmdRead, 8'hFF, 11'd1999));
    send_item(make_item(CmdRead, 8'h00, 11'd2000));
    send_item(make_item(CmdRead, 8'hFF, 11'd2047));
    send_item(make_item(CmdRead, 8'h00, 11'd1023));
    stop_sending();
  endtask

  task automatic test_control_chars();
    wait_for_results();
    send_item(make_item(CmdPut, 8'h00, 11'd2047));
    send_item(make_item(CmdPut, 8'hFF, 11'd0));
    send_item(make_item(CmdPut, CharBackspace, 11'd0));
    send_item(make_item(CmdPut, CharBackspace, 11'd0));
    send_item(make_item(CmdPut, CharBackspace, 11'd0));  // at top-left
    send_item(make_item(CmdPut, CharNewline, 11'd0));
    send_item(make_item(CmdPut, CharBackspace, 11'd0));  // column zero, wraps up
    send_item(make_item(CmdPut, 8'h41, 11'd0));          // last column, wraps down
    send_item(make_item(CmdRead, 8'h00, 11'd79));
    send_item(make_item(CmdRead, 8'h00, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd1));
    stop_sending();
  endtask

  task automatic test_attribute();
    wait_for_results();
    write_attribute(8'h00);
    send_item(make_item(CmdPut, 8'h55, 11'd0));
    stop_sending();
    wait_for_results();
    write_attribute(8'hFF);
    send_item(make_item(CmdPut, CharBackspace, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd80));
    send_item(make_item(CmdPut, 8'hAA, 11'd0));
    send_item(make_item(CmdRead, 8'h00, 11'd80));
    stop_sending();
  endtask

  task automatic test_random_text(int snd_pct, int rcv_pct, logic [7:0] attr, int count);
    wait_for_results();
    write_attribute(attr);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    send_random_text(count);
    stop_sending();
  endtask

  task automatic test_backpressure();
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 3000;
    send_random_text(40);
    stop_sending();
    wait_for_results();
    send_random_text(8);
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    send_random_text(8);
    stop_sending();
  endtask

  initial begin
    for (int i = 0; i < CellCount; i++) screen_shadow[i] = ResetCell;
    cursor_col_q = 0;
    cursor_row_q = 0;
    attr_q       = ResetAttr;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_screen();
    test_control_chars();
    test_attribute();
    test_random_text(9, 57, 8'hFF, 340);
    test_random_text(57, 9, 8'($urandom_range(0, 255)), 340);
    test_random_text(0, 0, ResetAttr, 340);
    test_backpressure();
    wait_for_results();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
